[hw/rtl/sdar_pkg.sv]
// ----------------------------------------------------------------------------
// sdar_pkg
// Shared types and constants for the stick dead-zone and auto-repeat block.
// ----------------------------------------------------------------------------
package sdar_pkg;

	// Width of the millisecond time base; now_ms is taken modulo 2^TIME_BITS.
	localparam int TIME_BITS = 48;

	localparam int AXIS_W    = 16;
	localparam int DZ_W      = 15;
	localparam int DELAY_W   = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Result queue between the lanes and the output channel.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [DZ_W-1:0]    DEAD_ZONE_RST     = DZ_W'(16000);
	localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = DELAY_W'(340);
	localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = DELAY_W'(115);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEAD_ZONE     = 2'd0,
		CFG_INITIAL_DELAY = 2'd1,
		CFG_REPEAT_DELAY  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_BUTTON = 2'd1,
		KIND_DETACH = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_NEG  = 2'd1,
		DIR_POS  = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		ACT_LEFT   = 3'd0,
		ACT_RIGHT  = 3'd1,
		ACT_UP     = 3'd2,
		ACT_DOWN   = 3'd3,
		ACT_ACCEPT = 3'd4,
		ACT_BACK   = 3'd5
	} action_t;

	typedef struct packed {
		logic [DZ_W-1:0]    dead_zone;
		logic [DELAY_W-1:0] initial_delay;
		logic [DELAY_W-1:0] repeat_delay;
	} cfg_t;

	// What one axis lane found for the current sample.
	typedef struct packed {
		logic emit;
		logic pos;
	} lane_res_t;

	typedef struct packed {
		action_t action;
		logic    last;
	} entry_t;

endpackage

[hw/rtl/sdar_axis.sv]
// ----------------------------------------------------------------------------
// sdar_axis
// One axis lane: dead-zone classification, direction and repeat-time state.
// ----------------------------------------------------------------------------
module sdar_axis (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  sdar_pkg::kind_t                    kind,
	input  logic [sdar_pkg::TIME_BITS-1:0]     now_ms,
	input  logic signed [sdar_pkg::AXIS_W-1:0] axis,
	input  sdar_pkg::cfg_t                     cfg,
	output sdar_pkg::lane_res_t                res
);

	sdar_pkg::dir_t                    dir_q;
	logic [sdar_pkg::TIME_BITS-1:0]    due_q;
	sdar_pkg::dir_t                    dir_new;
	logic signed [sdar_pkg::AXIS_W:0]  pos_ext;
	logic signed [sdar_pkg::AXIS_W:0]  dz_ext;
	logic [sdar_pkg::DELAY_W-1:0]      delay;
	logic [sdar_pkg::TIME_BITS:0]      sum;
	logic [sdar_pkg::TIME_BITS-1:0]    due_new;
	logic                              changed;
	logic                              due_hit;
	logic                              sample;

	assign sample  = accept && (kind == sdar_pkg::KIND_SAMPLE);
	assign pos_ext = (sdar_pkg::AXIS_W+1)'(axis);
	assign dz_ext  = $signed({2'b00, cfg.dead_zone});

	always_comb begin
		if (pos_ext < -dz_ext) begin
			dir_new = sdar_pkg::DIR_NEG;
		end else if (pos_ext > dz_ext) begin
			dir_new = sdar_pkg::DIR_POS;
		end else begin
			dir_new = sdar_pkg::DIR_NONE;
		end
	end

	assign changed = (dir_q != dir_new);
	assign due_hit = (now_ms >= due_q);
	assign delay   = changed ? cfg.initial_delay : cfg.repeat_delay;

	// Saturating add: a carry out of the time base clamps to its largest value.
	assign sum     = {1'b0, now_ms} + (sdar_pkg::TIME_BITS+1)'(delay);
	assign due_new = sum[sdar_pkg::TIME_BITS] ? '1 : sum[sdar_pkg::TIME_BITS-1:0];

	assign res.emit = (dir_new != sdar_pkg::DIR_NONE) && (changed || due_hit);
	assign res.pos  = (dir_new == sdar_pkg::DIR_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= sdar_pkg::DIR_NONE;
			due_q <= '0;
		end else if (sample) begin
			dir_q <= dir_new;
			if (changed || ((dir_new != sdar_pkg::DIR_NONE) && due_hit)) begin
				due_q <= due_new;
			end
		end else if (accept && (kind == sdar_pkg::KIND_DETACH)) begin
			dir_q <= sdar_pkg::DIR_NONE;
		end
	end

endmodule

[hw/rtl/sdar_merge.sv]
// ----------------------------------------------------------------------------
// sdar_merge
// Merges the lane results and button actions into an ordered result queue.
// ----------------------------------------------------------------------------
module sdar_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  sdar_pkg::kind_t     kind,
	input  logic [3:0]          button,
	input  sdar_pkg::lane_res_t res_x,
	input  sdar_pkg::lane_res_t res_y,
	input  logic                out_stall,
	output logic                out_valid,
	output sdar_pkg::entry_t    head,
	output logic                full
);

	sdar_pkg::entry_t                fifo_q [sdar_pkg::QDEPTH];
	logic [sdar_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [sdar_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [sdar_pkg::QCNT_W-1:0]     cnt_q;
	logic [1:0]                      n_push;
	sdar_pkg::entry_t                e0;
	sdar_pkg::entry_t                e1;
	sdar_pkg::action_t               act_x;
	sdar_pkg::action_t               act_y;
	logic                            pop;
	logic [1:0]                      n_acc;

	assign act_x = res_x.pos ? sdar_pkg::ACT_RIGHT : sdar_pkg::ACT_LEFT;
	assign act_y = res_y.pos ? sdar_pkg::ACT_DOWN : sdar_pkg::ACT_UP;

	// The X axis goes first; the final entry of a transaction carries last.
	always_comb begin
		n_push = 2'd0;
		e0     = '{action: sdar_pkg::ACT_LEFT, last: 1'b1};
		e1     = '{action: act_y, last: 1'b1};
		unique case (kind)
			sdar_pkg::KIND_SAMPLE: begin
				if (res_x.emit && res_y.emit) begin
					n_push = 2'd2;
					e0     = '{action: act_x, last: 1'b0};
				end else if (res_x.emit) begin
					n_push = 2'd1;
					e0     = '{action: act_x, last: 1'b1};
				end else if (res_y.emit) begin
					n_push = 2'd1;
					e0     = '{action: act_y, last: 1'b1};
				end
			end
			sdar_pkg::KIND_BUTTON: begin
				if (button <= 4'(sdar_pkg::ACT_BACK)) begin
					n_push = 2'd1;
					e0     = '{action: sdar_pkg::action_t'(button[2:0]), last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	assign n_acc     = accept ? n_push : 2'd0;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = fifo_q[rd_ptr_q];
	assign full      = (cnt_q > sdar_pkg::QCNT_W'(sdar_pkg::QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_acc != 2'd0) begin
			fifo_q[wr_ptr_q] <= e0;
		end
		if (n_acc == 2'd2) begin
			fifo_q[wr_ptr_q + sdar_pkg::QPTR_W'(1)] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sdar_pkg::QPTR_W'(n_acc);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sdar_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + sdar_pkg::QCNT_W'(n_acc) - sdar_pkg::QCNT_W'(pop);
		end
	end

endmodule

[hw/rtl/stick_deadzone_auto_repeat.sv]
// ----------------------------------------------------------------------------
// stick_deadzone_auto_repeat
// Game controller stick dead-zone classifier with auto-repeat and buttons.
// ----------------------------------------------------------------------------
// An input transaction is taken whole: the X and Y lanes classify and
// update their state in parallel, and up to two results enter a four-entry
// result queue that drives the output channel. A new input is accepted every
// cycle while the queue has room for two more results, so the sustained rate
// is set by the output channel, which delivers one result per cycle while
// out_stall is low. The results of an input are registered in the queue and
// reach the output once the results ahead of them have left.
module stick_deadzone_auto_repeat (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sdar_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sdar_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         kind,
	input  logic [sdar_pkg::TIME_BITS-1:0]     now_ms,
	input  logic signed [sdar_pkg::AXIS_W-1:0] axis_x,
	input  logic signed [sdar_pkg::AXIS_W-1:0] axis_y,
	input  logic [3:0]                         button,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         action,
	output logic                               last
);

	sdar_pkg::cfg_t      cfg_q;
	sdar_pkg::kind_t     kind_e;
	sdar_pkg::lane_res_t res_x;
	sdar_pkg::lane_res_t res_y;
	sdar_pkg::entry_t    head;
	logic                accept;
	logic                full;

	assign kind_e   = sdar_pkg::kind_t'(kind);
	assign in_stall = full;
	assign accept   = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone     <= sdar_pkg::DEAD_ZONE_RST;
			cfg_q.initial_delay <= sdar_pkg::INITIAL_DELAY_RST;
			cfg_q.repeat_delay  <= sdar_pkg::REPEAT_DELAY_RST;
		end else if (cfg_we) begin
			unique case (sdar_pkg::cfg_idx_t'(cfg_index))
				sdar_pkg::CFG_DEAD_ZONE:     cfg_q.dead_zone <= cfg_data[sdar_pkg::DZ_W-1:0];
				sdar_pkg::CFG_INITIAL_DELAY: cfg_q.initial_delay <= cfg_data;
				sdar_pkg::CFG_REPEAT_DELAY:  cfg_q.repeat_delay <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sdar_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (kind_e),
		.now_ms (now_ms),
		.axis   (axis_x),
		.cfg    (cfg_q),
		.res    (res_x)
	);

	sdar_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (kind_e),
		.now_ms (now_ms),
		.axis   (axis_y),
		.cfg    (cfg_q),
		.res    (res_y)
	);

	sdar_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind_e),
		.button    (button),
		.res_x     (res_x),
		.res_y     (res_y),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.full      (full)
	);

	assign action = head.action;
	assign last   = head.last;

endmodule

[hw/rtl/sdar_checker.sv]
// ----------------------------------------------------------------------------
// sdar_checker
// Port-level checks for the stick dead-zone and auto-repeat block.
// ----------------------------------------------------------------------------
module sdar_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] kind,
	input logic [3:0] button,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] action,
	input logic       last
);

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action) && $stable(last))
		else $error("stalled result changed");

	// Only the six defined actions ever leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action <= 3'(sdar_pkg::ACT_BACK)))
		else $error("undefined action code");

	// Both results of a transaction are queued together, so the second follows.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("second result of a pair missing");

	// An accepted mapped button press always leaves the output valid on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == sdar_pkg::KIND_BUTTON) &&
		(button <= 4'(sdar_pkg::ACT_BACK))
		|=> out_valid)
		else $error("button transaction produced no result");

endmodule

bind stick_deadzone_auto_repeat sdar_checker u_sdar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.button    (button),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.action    (action),
	.last      (last)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the stick dead-zone and auto-repeat block.
// ----------------------------------------------------------------------------
// A queue of stimulus items feeds a driver that presents one transaction at a
// time, with random gaps in some phases. Every accepted transaction runs
// through a predictor that keeps its own copy of the axis directions, repeat
// times and settings. The predicted navigation actions wait in order. A
// monitor stalls the output at random in some phases and compares each
// result with the oldest waiting action. The run opens with a directed
// sequence at reset settings. It then steps through phases of random
// traffic, and each phase writes new settings while the block is idle.
module tb_top;

	localparam int           PHASES          = 8;
	localparam int           ITEMS_PER_PHASE = 210;
	localparam int           MAX_IDLE        = 18;
	localparam int           LONG_HOLD       = 300;
	localparam int           WATCHDOG_LIMIT  = 2000;
	localparam int           SETTLE_CYCLES   = 8;
	localparam logic [1:0]   KIND_UNUSED     = 2'd3;
	localparam logic [1:0]   CFG_UNUSED_IDX  = 2'd3;
	localparam logic [3:0]   BTN_UNUSED_LO   = 4'd6;
	localparam logic [3:0]   BTN_UNUSED_HI   = 4'd15;
	localparam logic [sdar_pkg::TIME_BITS-1:0] TIME_MAX = '1;

	typedef struct {
		logic [1:0]                          kind;
		logic [sdar_pkg::TIME_BITS-1:0]      now;
		logic signed [sdar_pkg::AXIS_W-1:0]  ax;
		logic signed [sdar_pkg::AXIS_W-1:0]  ay;
		logic [3:0]                          btn;
	} stim_t;

	logic                                 clk       = 1'b0;
	logic                                 arst_n    = 1'b0;
	logic                                 cfg_we    = 1'b0;
	logic [sdar_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [sdar_pkg::CFG_W-1:0]           cfg_data  = '0;
	logic                                 in_valid  = 1'b0;
	logic                                 in_stall;
	logic [1:0]                           kind      = '0;
	logic [sdar_pkg::TIME_BITS-1:0]       now_ms    = '0;
	logic signed [sdar_pkg::AXIS_W-1:0]   axis_x    = '0;
	logic signed [sdar_pkg::AXIS_W-1:0]   axis_y    = '0;
	logic [3:0]                           button    = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b1;
	logic [2:0]                           action;
	logic                                 last;

	stick_deadzone_auto_repeat u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.now_ms    (now_ms),
		.axis_x    (axis_x),
		.axis_y    (axis_y),
		.button    (button),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.action    (action),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state and its copy of the settings.
	logic [sdar_pkg::DZ_W-1:0]      dz_mirror   = sdar_pkg::DEAD_ZONE_RST;
	logic [sdar_pkg::DELAY_W-1:0]   init_mirror = sdar_pkg::INITIAL_DELAY_RST;
	logic [sdar_pkg::DELAY_W-1:0]   rpt_mirror  = sdar_pkg::REPEAT_DELAY_RST;
	sdar_pkg::dir_t                 stick_dir[2] = '{sdar_pkg::DIR_NONE, sdar_pkg::DIR_NONE};
	logic [sdar_pkg::TIME_BITS-1:0] rep_due[2]   = '{'0, '0};

	stim_t            pending_items[$];
	sdar_pkg::entry_t nav_expected[$];

	int  queued_cnt    = 0;
	int  in_taken_cnt  = 0;
	int  fail_cnt      = 0;
	int  quiet_cycles  = 0;
	int  send_wait     = 0;
	int  recv_wait     = 0;
	bit  in_took       = 1'b0;
	bit  out_took      = 1'b0;
	bit  send_idle_on  = 1'b0;
	bit  recv_idle_on  = 1'b0;
	bit  recv_long_req = 1'b0;

	// Stimulus generator state.
	logic [sdar_pkg::TIME_BITS-1:0]     gen_now = '0;
	logic signed [sdar_pkg::AXIS_W-1:0] prev_x  = '0;
	logic signed [sdar_pkg::AXIS_W-1:0] prev_y  = '0;
	int                                 step_hi = 40;

	function automatic logic [sdar_pkg::TIME_BITS-1:0] due_after(
			logic [sdar_pkg::TIME_BITS-1:0] t, logic [sdar_pkg::DELAY_W-1:0] d);
		logic [sdar_pkg::TIME_BITS:0] s;
		s = {1'b0, t} + (sdar_pkg::TIME_BITS + 1)'(d);
		return s[sdar_pkg::TIME_BITS] ? TIME_MAX : s[sdar_pkg::TIME_BITS-1:0];
	endfunction

	function automatic sdar_pkg::dir_t classify(logic signed [sdar_pkg::AXIS_W-1:0] pos);
		int p;
		int d;
		p = pos;
		d = int'(dz_mirror);
		if (p < -d)
			return sdar_pkg::DIR_NEG;
		if (p > d)
			return sdar_pkg::DIR_POS;
		return sdar_pkg::DIR_NONE;
	endfunction

	function automatic logic lane_step(int lane, sdar_pkg::dir_t d,
			logic [sdar_pkg::TIME_BITS-1:0] t, output sdar_pkg::action_t a);
		logic fire;
		fire = 1'b0;
		if (stick_dir[lane] != d) begin
			stick_dir[lane] = d;
			rep_due[lane] = due_after(t, init_mirror);
			fire = (d != sdar_pkg::DIR_NONE);
		end else if (d != sdar_pkg::DIR_NONE && t >= rep_due[lane]) begin
			rep_due[lane] = due_after(t, rpt_mirror);
			fire = 1'b1;
		end
		if (lane == 0)
			a = (d == sdar_pkg::DIR_POS) ? sdar_pkg::ACT_RIGHT : sdar_pkg::ACT_LEFT;
		else
			a = (d == sdar_pkg::DIR_POS) ? sdar_pkg::ACT_DOWN : sdar_pkg::ACT_UP;
		return fire;
	endfunction

	function automatic void predict_actions(logic [1:0] k,
			logic [sdar_pkg::TIME_BITS-1:0] t, logic signed [sdar_pkg::AXIS_W-1:0] ax,
			logic signed [sdar_pkg::AXIS_W-1:0] ay, logic [3:0] b);
		sdar_pkg::action_t acts[$];
		sdar_pkg::action_t a;
		if (k == sdar_pkg::KIND_SAMPLE) begin
			if (lane_step(0, classify(ax), t, a))
				acts.push_back(a);
			if (lane_step(1, classify(ay), t, a))
				acts.push_back(a);
		end else if (k == sdar_pkg::KIND_BUTTON) begin
			if (b <= 4'(sdar_pkg::ACT_BACK))
				acts.push_back(sdar_pkg::action_t'(b[2:0]));
		end else if (k == sdar_pkg::KIND_DETACH) begin
			stick_dir[0] = sdar_pkg::DIR_NONE;
			stick_dir[1] = sdar_pkg::DIR_NONE;
		end
		foreach (acts[i])
			nav_expected.push_back('{action: acts[i], last: (i == acts.size() - 1)});
	endfunction

	// Input side: predict on every accepted transaction.
	always @(posedge clk) begin
		in_took = arst_n && in_valid && !in_stall;
		if (in_took) begin
			predict_actions(kind, now_ms, axis_x, axis_y, button);
			in_taken_cnt++;
		end
	end

	// Driver: holds a payload until it is taken, then waits its drawn gap.
	always @(negedge clk) begin
		stim_t it;
		if (arst_n && (!in_valid || in_took)) begin
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				it = pending_items.pop_front();
				kind      <= it.kind;
				now_ms    <= it.now;
				axis_x    <= it.ax;
				axis_y    <= it.ay;
				button    <= it.btn;
				in_valid  <= 1'b1;
				send_wait = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		sdar_pkg::entry_t e;
		out_took = arst_n && out_valid && !out_stall;
		if (out_took) begin
			if (nav_expected.size() == 0) begin
				$error("unexpected result: action %0d last %0d", action, last);
				fail_cnt++;
			end else begin
				e = nav_expected.pop_front();
				if (action !== e.action) begin
					$error("action mismatch: expected %0d, actual %0d", e.action, action);
					fail_cnt++;
				end
				if (last !== e.last) begin
					$error("last mismatch: expected %0d, actual %0d", e.last, last);
					fail_cnt++;
				end
			end
		end
	end

	// Receiver stall: a drawn wait after each result, or one long hold-off.
	always @(negedge clk) begin
		if (recv_long_req) begin
			recv_wait = LONG_HOLD;
			recv_long_req = 1'b0;
		end else if (out_took) begin
			recv_wait = recv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		end
		if (recv_wait > 0) begin
			recv_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("stick_deadzone_auto_repeat verification failed");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

	function automatic stim_t mk(logic [1:0] k, logic [sdar_pkg::TIME_BITS-1:0] t,
			logic signed [sdar_pkg::AXIS_W-1:0] ax, logic signed [sdar_pkg::AXIS_W-1:0] ay,
			logic [3:0] b);
		stim_t s;
		s.kind = k;
		s.now  = t;
		s.ax   = ax;
		s.ay   = ay;
		s.btn  = b;
		return s;
	endfunction

	function automatic logic [sdar_pkg::TIME_BITS-1:0] rand_time();
		return sdar_pkg::TIME_BITS'({$urandom, $urandom});
	endfunction

	function automatic logic signed [sdar_pkg::AXIS_W-1:0] axis_pick(
			logic signed [sdar_pkg::AXIS_W-1:0] prev);
		int r;
		int bnd;
		r = $urandom_range(0, 99);
		bnd = int'(dz_mirror) + $urandom_range(0, 1);
		if (bnd > 32767)
			bnd = 32767;
		if (r < 50)
			return prev;
		if (r < 60)
			return '0;
		if (r < 72)
			return $urandom_range(0, 1) ? sdar_pkg::AXIS_W'(bnd) : sdar_pkg::AXIS_W'(-bnd);
		if (r < 78)
			return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		return sdar_pkg::AXIS_W'($urandom);
	endfunction

	// Mostly samples that hold or move the stick over a rising clock, so the
	// repeat timers actually fire; the rest is buttons, detaches and noise.
	function automatic stim_t rand_item();
		stim_t s;
		int r;
		s = mk(sdar_pkg::KIND_SAMPLE, rand_time(), sdar_pkg::AXIS_W'($urandom),
			sdar_pkg::AXIS_W'($urandom), 4'($urandom));
		r = $urandom_range(0, 99);
		if (r < 72) begin
			gen_now += sdar_pkg::TIME_BITS'($urandom_range(0, step_hi));
			prev_x = axis_pick(prev_x);
			prev_y = axis_pick(prev_y);
			s.now = gen_now;
			s.ax  = prev_x;
			s.ay  = prev_y;
		end else if (r < 84) begin
			s.kind = sdar_pkg::KIND_BUTTON;
			if (r < 80)
				s.btn = 4'($urandom_range(0, int'(sdar_pkg::ACT_BACK)));
		end else if (r < 90) begin
			s.kind = sdar_pkg::KIND_DETACH;
		end else if (r < 94) begin
			s.kind = KIND_UNUSED;
		end
		return s;
	endfunction

	task automatic push_item(stim_t s);
		pending_items.push_back(s);
		queued_cnt++;
	endtask

	task automatic wait_drained();
		while (in_taken_cnt != queued_cnt || nav_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Called at a falling edge; the write lands at the next rising edge.
	task automatic cfg_write(logic [sdar_pkg::CFG_IDX_W-1:0] idx,
			logic [sdar_pkg::CFG_W-1:0] data);
		case (idx)
			sdar_pkg::CFG_DEAD_ZONE:     dz_mirror   = data[sdar_pkg::DZ_W-1:0];
			sdar_pkg::CFG_INITIAL_DELAY: init_mirror = data;
			sdar_pkg::CFG_REPEAT_DELAY:  rpt_mirror  = data;
			default: ;
		endcase
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	initial begin
		logic [sdar_pkg::DZ_W-1:0]    dzv;
		logic [sdar_pkg::DELAY_W-1:0] initv;
		logic [sdar_pkg::DELAY_W-1:0] rptv;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings: dead zone 16000, delays 340 and 115.
		push_item(mk(sdar_pkg::KIND_BUTTON, '0, '0, '0, 4'(sdar_pkg::ACT_LEFT)));
		push_item(mk(sdar_pkg::KIND_BUTTON, '0, '0, '0, 4'(sdar_pkg::ACT_RIGHT)));
		push_item(mk(sdar_pkg::KIND_BUTTON, '0, '0, '0, 4'(sdar_pkg::ACT_UP)));
		push_item(mk(sdar_pkg::KIND_BUTTON, '0, '0, '0, 4'(sdar_pkg::ACT_DOWN)));
		push_item(mk(sdar_pkg::KIND_BUTTON, '0, '0, '0, 4'(sdar_pkg::ACT_ACCEPT)));
		push_item(mk(sdar_pkg::KIND_BUTTON, '0, '0, '0, 4'(sdar_pkg::ACT_BACK)));
		push_item(mk(sdar_pkg::KIND_BUTTON, '0, '0, '0, BTN_UNUSED_LO));
		push_item(mk(sdar_pkg::KIND_BUTTON, TIME_MAX, 16'sh7FFF, 16'sh8000, BTN_UNUSED_HI));
		push_item(mk(KIND_UNUSED, TIME_MAX, 16'sh8000, 16'sh7FFF, 4'(sdar_pkg::ACT_ACCEPT)));
		push_item(mk(sdar_pkg::KIND_SAMPLE, 48'd1000, 16'sh8000, 16'sh7FFF, '0));
		push_item(mk(sdar_pkg::KIND_SAMPLE, 48'd1100, 16'sh8000, 16'sh7FFF, '0));
		push_item(mk(sdar_pkg::KIND_SAMPLE, 48'd1340, 16'sh8000, 16'sh7FFF, '0));
		push_item(mk(sdar_pkg::KIND_SAMPLE, 48'd1455, 16'sd16001, -16'sd16001, '0));
		// Both axes sit exactly on the threshold: back to center, silently.
		push_item(mk(sdar_pkg::KIND_SAMPLE, 48'd1460, 16'sd16000, -16'sd16000, '0));
		push_item(mk(sdar_pkg::KIND_SAMPLE, 48'd1470, '0, 16'sd16001, '0));
		push_item(mk(sdar_pkg::KIND_DETACH, 48'd1475, 16'sd20000, 16'sd20000, '0));
		push_item(mk(sdar_pkg::KIND_SAMPLE, 48'd1480, '0, 16'sd16001, '0));
		// Near the top of the time base the repeat time saturates.
		push_item(mk(sdar_pkg::KIND_SAMPLE, TIME_MAX - 48'd100, -16'sd16001, '0, '0));
		push_item(mk(sdar_pkg::KIND_SAMPLE, TIME_MAX, -16'sd16001, '0, '0));
		push_item(mk(sdar_pkg::KIND_SAMPLE, TIME_MAX, -16'sd16001, '0, '0));
		push_item(mk(sdar_pkg::KIND_SAMPLE, TIME_MAX, 16'sh7FFF, 16'sh8000, '0));
		push_item(mk(sdar_pkg::KIND_DETACH, '0, '0, '0, '0));
		push_item(mk(sdar_pkg::KIND_SAMPLE, 48'd10, 16'sh7FFF, 16'sh8000, '0));

		for (int ph = 1; ph <= PHASES; ph++) begin
			wait_drained();
			send_idle_on = (ph % 2 == 0) || (ph == 5);
			recv_idle_on = (ph % 2 == 0) || (ph == 7) || (ph == 3);
			gen_now = rand_time() >> $urandom_range(0, sdar_pkg::TIME_BITS - 1);
			case (ph)
				1: begin
					dzv = '0; initv = '0; rptv = '0; step_hi = 3;
				end
				2: begin
					dzv = '1; initv = '1; rptv = '1; step_hi = 30000;
				end
				4: begin
					dzv = sdar_pkg::DZ_W'($urandom);
					initv = sdar_pkg::DELAY_W'($urandom_range(30000, 65535));
					rptv = sdar_pkg::DELAY_W'($urandom);
					gen_now = TIME_MAX - sdar_pkg::TIME_BITS'(5000);
					step_hi = 400;
				end
				default: begin
					dzv = sdar_pkg::DZ_W'($urandom);
					initv = sdar_pkg::DELAY_W'($urandom_range(0, 400));
					rptv = sdar_pkg::DELAY_W'($urandom_range(0, 150));
					step_hi = 60;
				end
			endcase
			cfg_write(sdar_pkg::CFG_DEAD_ZONE, {1'($urandom), dzv});
			cfg_write(sdar_pkg::CFG_INITIAL_DELAY, initv);
			cfg_write(sdar_pkg::CFG_REPEAT_DELAY, rptv);
			if (ph == 5)
				cfg_write(CFG_UNUSED_IDX, sdar_pkg::CFG_W'($urandom));
			cfg_we <= 1'b0;
			// The receiver holds off while the sender keeps the input busy.
			if (ph == 3)
				recv_long_req = 1'b1;
			repeat (ITEMS_PER_PHASE) push_item(rand_item());
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_cnt == 0 && nav_expected.size() == 0)
			$display("stick_deadzone_auto_repeat verification clean");
		else
			$display("stick_deadzone_auto_repeat verification failed");
		$finish;
	end

endmodule
